// ===== rtl/ssd_pkg.sv =====
// Shared types and constants for the speech segment detector.
// Used by ssd_buf_stats and speech_segment_detector; no dependencies.
`default_nettype none

package ssd_pkg;

    // widths
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 17;
    localparam int CFG_W    = 16;
    localparam int COUNT_W  = 11;
    localparam int SUM_W    = 17;
    localparam int PAUSE_W  = 17;
    localparam int POS_W    = 2;
    localparam int PHASE_W  = 2;
    localparam int LEVEL_W  = 16;
    localparam int PROD_W   = 27;
    localparam int DIV_W    = 33;

    // saturation limits and scales
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 11'd2047;
    localparam logic [PAUSE_W-1:0] PAUSE_MAX   = 17'd131071;
    localparam logic [9:0]         RATIO_SCALE = 10'd1000;
    localparam logic [POS_W-1:0]   HEAD_LEN    = 2'd3;
    localparam logic [PHASE_W-1:0] PHASE_LAST  = 2'd2;

    // divide by three: floor(x / 3) = (x * 43691) >> 17 for x below 2^17
    localparam logic [15:0] DIV3_RECIP = 16'd43691;
    localparam int          DIV3_SHIFT = 17;

    // register reset values
    localparam logic [CFG_W-1:0] NOISE_THRESHOLD_RST = 16'd256;
    localparam logic [CFG_W-1:0] SIGNAL_LEVEL_RST    = 16'd500;
    localparam logic [CFG_W-1:0] MAX_PAUSE_RST       = 16'd20;

    // register indexes
    typedef enum logic [1:0] {
        REG_NOISE_THRESHOLD = 2'd0,
        REG_SIGNAL_LEVEL    = 2'd1,
        REG_MAX_PAUSE       = 2'd2
    } cfg_reg_t;

    // one staged word handed to the statistics unit
    typedef struct packed {
        logic             en;
        logic             quiet;
        logic             last;
        logic [MAG_W-1:0] mag;
    } step_t;

    // buffer statistics including the word being processed
    typedef struct packed {
        logic [COUNT_W-1:0] quiet_cnt;
        logic [COUNT_W-1:0] loud_cnt;
        logic [SUM_W-1:0]   head_sum;
    } stats_t;

endpackage

`default_nettype wire

// ===== rtl/ssd_buf_stats.sv =====
// Per-buffer statistics: quiet and loud counts and sum of head magnitudes.
// Depends on ssd_pkg.
`default_nettype none

module ssd_buf_stats (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ssd_pkg::step_t step,
    output ssd_pkg::stats_t    stats
);

    logic [ssd_pkg::COUNT_W-1:0] quiet_cnt_reg, quiet_cnt_next;
    logic [ssd_pkg::COUNT_W-1:0] loud_cnt_reg, loud_cnt_next;
    logic [ssd_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [ssd_pkg::SUM_W-1:0]   head_sum_reg, head_sum_next;
    ssd_pkg::stats_t             cur;

    // counts and head sum with the current word folded in
    always_comb
    begin
        cur.quiet_cnt = quiet_cnt_reg;
        cur.loud_cnt  = loud_cnt_reg;
        cur.head_sum  = head_sum_reg;
        if (step.quiet)
        begin
            if (quiet_cnt_reg < ssd_pkg::COUNT_MAX)
                cur.quiet_cnt = quiet_cnt_reg + 1'b1;
        end
        else
        begin
            if (loud_cnt_reg < ssd_pkg::COUNT_MAX)
                cur.loud_cnt = loud_cnt_reg + 1'b1;
        end
        if (pos_reg < ssd_pkg::HEAD_LEN)
            cur.head_sum = head_sum_reg + step.mag;
    end

    assign stats = cur;

    // next state: restart at the end of a buffer
    always_comb
    begin
        quiet_cnt_next = quiet_cnt_reg;
        loud_cnt_next  = loud_cnt_reg;
        pos_next       = pos_reg;
        head_sum_next  = head_sum_reg;
        if (step.en)
        begin
            if (step.last)
            begin
                quiet_cnt_next = ssd_pkg::COUNT_W'(1);
                loud_cnt_next  = ssd_pkg::COUNT_W'(1);
                pos_next       = '0;
                head_sum_next  = '0;
            end
            else
            begin
                quiet_cnt_next = cur.quiet_cnt;
                loud_cnt_next  = cur.loud_cnt;
                head_sum_next  = cur.head_sum;
                if (pos_reg < ssd_pkg::HEAD_LEN)
                    pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cnt_reg <= ssd_pkg::COUNT_W'(1);
            loud_cnt_reg  <= ssd_pkg::COUNT_W'(1);
            pos_reg       <= '0;
            head_sum_reg  <= '0;
        end
        else
        begin
            quiet_cnt_reg <= quiet_cnt_next;
            loud_cnt_reg  <= loud_cnt_next;
            pos_reg       <= pos_next;
            head_sum_reg  <= head_sum_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/speech_segment_detector.sv =====
// Speech segment detector: one result word per buffer, on its last sample.
// Path: the last sample word is held in the input register until the result
// register is free, and its result word is then registered there.
// Throughput: one sample word per cycle; while a result waits, non-final words
// keep flowing, but a final word holds the input register until the result moves.
// Reset: rst_n asynchronous, active low; registers return to their defaults,
// counts to 1, pause count, speech flag and level phase to 0.
`default_nettype none

module speech_segment_detector (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [ssd_pkg::CFG_W-1:0]     cfg_data,
    // sample words
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [ssd_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                          last_in_buffer,
    // result words
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               keep_buffer,
    output logic                               segment_end,
    output logic                               level_valid,
    output logic [ssd_pkg::LEVEL_W-1:0]        level
);

    // configuration registers
    logic [ssd_pkg::CFG_W-1:0] noise_threshold_reg;
    logic [ssd_pkg::CFG_W-1:0] signal_level_reg;
    logic [ssd_pkg::CFG_W-1:0] max_pause_reg;

    // input stage
    logic                      s1_valid_reg;
    logic [ssd_pkg::MAG_W-1:0] s1_mag_reg;
    logic                      s1_quiet_reg;
    logic                      s1_last_reg;
    logic [ssd_pkg::MAG_W-1:0] in_mag;

    // decision state
    logic [ssd_pkg::PAUSE_W-1:0] pause_reg, pause_next;
    logic                        speech_seen_reg, speech_seen_next;
    logic [ssd_pkg::PHASE_W-1:0] phase_reg, phase_next;

    // result register
    logic                        out_valid_reg;
    logic                        keep_reg, keep_next;
    logic                        seg_end_reg, seg_end_next;
    logic                        lvl_valid_reg, lvl_valid_next;
    logic [ssd_pkg::LEVEL_W-1:0] level_reg, level_next;

    logic advance;
    logic proc;
    logic finish;

    ssd_pkg::step_t  step;
    ssd_pkg::stats_t stats;

    logic [ssd_pkg::PROD_W-1:0]  loud_scaled;
    logic [ssd_pkg::PROD_W-1:0]  quiet_scaled;
    logic [ssd_pkg::DIV_W-1:0]   div_prod;
    logic [ssd_pkg::PAUSE_W-1:0] pause_inc;
    logic                        unvoiced;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_threshold_reg <= ssd_pkg::NOISE_THRESHOLD_RST;
            signal_level_reg    <= ssd_pkg::SIGNAL_LEVEL_RST;
            max_pause_reg       <= ssd_pkg::MAX_PAUSE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ssd_pkg::REG_NOISE_THRESHOLD: noise_threshold_reg <= cfg_data;
                ssd_pkg::REG_SIGNAL_LEVEL:    signal_level_reg    <= cfg_data;
                ssd_pkg::REG_MAX_PAUSE:       max_pause_reg       <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // handshake: a non-final word always moves on, a final one needs the result slot
    assign advance  = !out_valid_reg || out_ready;
    assign proc     = s1_valid_reg && (!s1_last_reg || advance);
    assign finish   = proc && s1_last_reg;
    assign in_ready = !s1_valid_reg || proc;

    // magnitude of the incoming sample, -32768 gives 32768
    assign in_mag = sample[ssd_pkg::SAMPLE_W-1]
                    ? (ssd_pkg::MAG_W'(0) - {1'b1, sample})
                    : {1'b0, sample};

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_mag_reg   <= in_mag;
            s1_quiet_reg <= (in_mag < {1'b0, noise_threshold_reg});
            s1_last_reg  <= last_in_buffer;
        end
    end

    // buffer statistics
    assign step = '{en: proc, quiet: s1_quiet_reg, last: s1_last_reg, mag: s1_mag_reg};

    ssd_buf_stats u_stats (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .stats (stats)
    );

    // ratio test by cross multiplication, mean of head by reciprocal
    assign loud_scaled  = ssd_pkg::PROD_W'(stats.loud_cnt) *
                          ssd_pkg::PROD_W'(ssd_pkg::RATIO_SCALE);
    assign quiet_scaled = ssd_pkg::PROD_W'(signal_level_reg) * ssd_pkg::PROD_W'(stats.quiet_cnt);
    assign unvoiced     = loud_scaled < quiet_scaled;
    assign div_prod     = ssd_pkg::DIV_W'(stats.head_sum) * ssd_pkg::DIV_W'(ssd_pkg::DIV3_RECIP);
    assign pause_inc    = (pause_reg < ssd_pkg::PAUSE_MAX) ? (pause_reg + 1'b1) : pause_reg;

    // buffer decision
    always_comb
    begin
        pause_next       = pause_reg;
        speech_seen_next = speech_seen_reg;
        phase_next       = phase_reg;
        keep_next        = 1'b0;
        seg_end_next     = 1'b0;
        lvl_valid_next   = 1'b0;
        level_next       = '0;
        if (!(unvoiced && !speech_seen_reg))
        begin
            keep_next        = 1'b1;
            speech_seen_next = 1'b1;
            pause_next       = unvoiced ? pause_inc : '0;
            if (phase_reg == ssd_pkg::PHASE_LAST)
            begin
                lvl_valid_next = 1'b1;
                level_next     = div_prod[ssd_pkg::DIV3_SHIFT+ssd_pkg::LEVEL_W-1:
                                          ssd_pkg::DIV3_SHIFT];
                phase_next     = '0;
            end
            else
            begin
                phase_next = phase_reg + 1'b1;
            end
            if (unvoiced && (pause_inc > {1'b0, max_pause_reg}))
            begin
                seg_end_next     = 1'b1;
                pause_next       = '0;
                speech_seen_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pause_reg       <= '0;
            speech_seen_reg <= 1'b0;
            phase_reg       <= '0;
        end
        else if (finish)
        begin
            pause_reg       <= pause_next;
            speech_seen_reg <= speech_seen_next;
            phase_reg       <= phase_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= finish;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            keep_reg      <= keep_next;
            seg_end_reg   <= seg_end_next;
            lvl_valid_reg <= lvl_valid_next;
            level_reg     <= level_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign keep_buffer = keep_reg;
    assign segment_end = seg_end_reg;
    assign level_valid = lvl_valid_reg;
    assign level       = level_reg;

`ifndef NO_ASSERTIONS
    // a closed segment leaves speech detection rearmed
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && seg_end_reg) |-> !speech_seen_reg)
        else $error("speech flag still set after segment end");

    // a dropped buffer reports nothing else
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !keep_reg) |-> (!seg_end_reg && !lvl_valid_reg))
        else $error("dropped buffer carries segment end or level");

    // level is zero unless it is reported
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !lvl_valid_reg) |-> (level_reg == '0))
        else $error("level non-zero without level_valid");

    // the level phase cycles through three values only
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("level phase out of range");
`endif

endmodule

`default_nettype wire
